@@ rtl/core/mlbta_pkg.sv @@
package mlbta_pkg;

	// field widths
	localparam int COORD_W  = 16;
	localparam int LEVEL_W  = 5;
	localparam int POS_W    = 16;
	localparam int WEIGHT_W = 32;
	localparam int PROD_W   = 40;
	localparam int ACC_W    = 48;

	// shared multiplier: half of the running product by a 32 bit operand
	localparam int PROD_HALF = PROD_W / 2;
	localparam int MUL_B_W   = 32;
	localparam int MUL_W     = PROD_HALF + MUL_B_W;

	// default parameter values
	localparam int FRAC_BITS_DEF = 16;
	localparam int MAX_LEVEL_DEF = 16;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic [COORD_W-1:0]         coord;
		logic [LEVEL_W-1:0]         level_exp;
		logic [POS_W-1:0]           grid_pos;
		logic signed [WEIGHT_W-1:0] weight;
		logic                       last_dim;
		logic                       last_point;
	} item_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] sum;
		logic                    saturated;
	} result_t;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_HAT    = 10'b00_0000_0010,
		ST_P_LO   = 10'b00_0000_0100,
		ST_P_HI   = 10'b00_0000_1000,
		ST_P_UPD  = 10'b00_0001_0000,
		ST_W_HI   = 10'b00_0010_0000,
		ST_W_LO   = 10'b00_0100_0000,
		ST_W_TERM = 10'b00_1000_0000,
		ST_W_ACC  = 10'b01_0000_0000,
		ST_FIN    = 10'b10_0000_0000
	} state_t;

endpackage

@@ rtl/core/modlinear_basis_transpose_accumulate.sv @@
// sequencing: a beat on a non-final dimension runs ST_HAT, ST_P_LO, ST_P_HI, ST_P_UPD, ST_FIN;
// a final-dimension beat adds ST_W_HI, ST_W_LO, ST_W_TERM and ST_W_ACC before ST_FIN; the sum
// beat is raised from ST_FIN of the last point, later while a previous sum is still unread
// a new beat is taken only in ST_IDLE, once the last one is through; the pace is set by the
// one 20x32 multiplier, used twice for the hat product and twice more for the weight
// reset (arst_n low): sequencer idle, running product 1.0, accumulator and flag cleared,
// no result pending
module modlinear_basis_transpose_accumulate
	import mlbta_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	localparam int F      = FRAC_BITS;
	localparam int UP     = (F >= COORD_W) ? F - COORD_W : 0;  // coord rescale, left
	localparam int DN     = (F < COORD_W) ? COORD_W - F : 0;   // coord rescale, right
	localparam int D_W    = COORD_W + MAX_LEVEL + F + 3;        // hat arithmetic width
	localparam int HAT_W  = F + 2;                              // hat is Q2.F, at most 2.0
	localparam int FULL_W = MUL_W + PROD_HALF;                  // full product update width
	localparam int LO_W   = MUL_W + 2;                          // low partial sum width
	localparam int Q_W    = ACC_W + 1;                          // weighted term magnitude
	localparam int TERM_HI = ACC_W - 1 - PROD_HALF;             // early term overflow bit

	localparam logic [PROD_W-1:0] PROD_ONE = PROD_W'(1) << F;

	state_t state_q, state_d;

	item_t               cur_q;          // captured beat
	logic [HAT_W-1:0]    hat_q;
	logic [MUL_B_W-1:0]  mag_q;          // weight magnitude
	logic [MUL_W-1:0]    mul_q;          // shared multiplier output
	logic [MUL_W-1:0]    part_q;         // first partial product held aside
	logic signed [ACC_W-1:0] term_q;
	logic [PROD_W-1:0]   prod_q;         // running product, Q.F
	logic signed [ACC_W-1:0] acc_q;
	logic                sat_q;
	logic                res_valid_q;
	result_t             res_q;

	// ---------------------------------------------------------------------
	// hat value, evaluated in ST_HAT from the captured beat
	// ---------------------------------------------------------------------
	logic [LEVEL_W-1:0]     lv;
	logic signed [D_W-1:0]  t_d, is_d, one_d, right_d, diff_d, abs_d, v_d;
	logic [HAT_W-1:0]       hat_d;

	always_comb begin
		// level clamped to the deepest supported level
		lv = (cur_q.level_exp > LEVEL_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL) : cur_q.level_exp;
		t_d     = $signed(((D_W'(cur_q.coord) << lv) << UP) >> DN);
		is_d    = $signed(D_W'(cur_q.grid_pos) << F);
		one_d   = $signed(D_W'(1) << F);
		right_d = $signed((D_W'(1) << lv) - D_W'(1));
		diff_d  = t_d - is_d;
		abs_d   = diff_d[D_W-1] ? -diff_d : diff_d;
		if (lv <= LEVEL_W'(1)) begin
			v_d = one_d;
		end else if (cur_q.grid_pos == POS_W'(1)) begin
			// left boundary ramp
			v_d = (one_d <<< 1) - t_d;
		end else if ($signed(D_W'(cur_q.grid_pos)) == right_d) begin
			// right boundary ramp
			v_d = diff_d + one_d;
		end else begin
			// interior hat
			v_d = one_d - abs_d;
		end
		hat_d = (v_d > 0) ? HAT_W'(v_d) : '0;
	end

	// ---------------------------------------------------------------------
	// shared multiplier operand select
	// ---------------------------------------------------------------------
	logic [PROD_HALF-1:0] mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic                 mul_en;

	always_comb begin
		mul_a  = prod_q[PROD_HALF-1:0];
		mul_b  = MUL_B_W'(hat_q);
		mul_en = 1'b0;
		case (state_q)
			ST_P_LO: begin
				mul_en = 1'b1;
			end
			ST_P_HI: begin
				mul_a  = prod_q[PROD_W-1:PROD_HALF];
				mul_en = 1'b1;
			end
			ST_W_HI: begin
				mul_a  = prod_q[PROD_W-1:PROD_HALF];
				mul_b  = mag_q;
				mul_en = 1'b1;
			end
			ST_W_LO: begin
				mul_b  = mag_q;
				mul_en = 1'b1;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// product update: (hi << 20) + lo, rescaled and clamped to 40 bits
	// ---------------------------------------------------------------------
	logic [FULL_W-1:0] full_d;
	logic              prod_ovf;
	logic [PROD_W-1:0] prod_new;

	always_comb begin
		full_d   = (FULL_W'(mul_q) << PROD_HALF) + FULL_W'(part_q);
		prod_ovf = |(full_d >> (F + PROD_W));
		prod_new = prod_ovf ? {PROD_W{1'b1}} : full_d[F +: PROD_W];
	end

	// ---------------------------------------------------------------------
	// weighted term: part_q = high half * mag, mul_q = low half * mag
	// ---------------------------------------------------------------------
	logic [LO_W-1:0]         lo_sum;
	logic [Q_W-1:0]          q_d, limit_d;
	logic                    w_neg, term_ovf;
	logic signed [ACC_W-1:0] term_d;

	always_comb begin
		w_neg   = cur_q.weight[WEIGHT_W-1];
		lo_sum  = (LO_W'(part_q[F-1:0]) << PROD_HALF) + LO_W'(mul_q);
		q_d     = (Q_W'(part_q >> F) << PROD_HALF) + Q_W'(lo_sum >> F);
		limit_d = w_neg ? (Q_W'(1) << (ACC_W - 1)) : ((Q_W'(1) << (ACC_W - 1)) - Q_W'(1));
		// high partial alone already past the range, or the exact magnitude past it
		term_ovf = (|(part_q >> (F + TERM_HI))) || (q_d > limit_d);
		if (term_ovf) begin
			term_d = w_neg ? ACC_MIN : ACC_MAX;
		end else begin
			term_d = w_neg ? -$signed(q_d[ACC_W-1:0]) : $signed(q_d[ACC_W-1:0]);
		end
	end

	// ---------------------------------------------------------------------
	// saturating accumulate
	// ---------------------------------------------------------------------
	logic signed [ACC_W:0]   sum_d;
	logic                    acc_ovf;
	logic signed [ACC_W-1:0] acc_new;

	always_comb begin
		sum_d   = {acc_q[ACC_W-1], acc_q} + {term_q[ACC_W-1], term_q};
		acc_ovf = sum_d[ACC_W] != sum_d[ACC_W-1];
		if (acc_ovf) begin
			acc_new = sum_d[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_new = sum_d[ACC_W-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------------
	logic accept;
	logic out_free;
	logic emit;

	assign accept   = item_valid && item_ready;
	assign out_free = !res_valid_q || res_ready;
	assign emit     = (state_q == ST_FIN) && cur_q.last_point && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_HAT;
			end
			ST_HAT:    state_d = ST_P_LO;
			ST_P_LO:   state_d = ST_P_HI;
			ST_P_HI:   state_d = ST_P_UPD;
			ST_P_UPD:  state_d = cur_q.last_dim ? ST_W_HI : ST_FIN;
			ST_W_HI:   state_d = ST_W_LO;
			ST_W_LO:   state_d = ST_W_TERM;
			ST_W_TERM: state_d = ST_W_ACC;
			ST_W_ACC:  state_d = ST_FIN;
			ST_FIN: begin
				// a finished run waits here only while the previous sum is still held
				if (!cur_q.last_point || out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prod_q      <= PROD_ONE;
			acc_q       <= '0;
			sat_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_P_UPD) begin
				prod_q <= prod_new;
				if (prod_ovf) sat_q <= 1'b1;
			end
			if (state_q == ST_W_TERM && term_ovf) sat_q <= 1'b1;
			if (state_q == ST_W_ACC) begin
				acc_q  <= acc_new;
				prod_q <= PROD_ONE;
				if (acc_ovf) sat_q <= 1'b1;
			end
			if (emit) begin
				// run is over: product, accumulator and flag back to their starting values, sum raised
				prod_q      <= PROD_ONE;
				acc_q       <= '0;
				sat_q       <= 1'b0;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) cur_q <= item;
		if (state_q == ST_HAT) begin
			hat_q <= hat_d;
			mag_q <= cur_q.weight[WEIGHT_W-1] ? (~cur_q.weight + 1'b1) : cur_q.weight;
		end
		if (mul_en) mul_q <= MUL_W'(mul_a) * MUL_W'(mul_b);
		if (state_q == ST_P_HI || state_q == ST_W_LO) part_q <= mul_q;
		if (state_q == ST_W_TERM) term_q <= term_d;
		if (emit) begin
			res_q.sum       <= acc_q;
			res_q.saturated <= sat_q;
		end
	end

	assign item_ready = (state_q == ST_IDLE);
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_HAT)
		else $error("accepted beat did not start the sequencer");

	a_res_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == ST_FIN) && $past(cur_q.last_point))
		else $error("result raised outside the end of a run");

	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> acc_q == '0 && !sat_q && prod_q == PROD_ONE)
		else $error("run state not cleared after the sum beat");

	a_prod_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_P_UPD) && prod_ovf |=> sat_q && prod_q == {PROD_W{1'b1}})
		else $error("product overflow not clamped and flagged");

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_W_ACC) |=> !item_ready)
		else $error("ready raised before the run state was settled");

endmodule
